FILE: design/sqm_pkg.sv
// ----------------------------------------------------------------------------
// sqm_pkg
// Shared types and codes for the stack/queue machine: request and response
// payloads, operation and status codes, sequencer states, memory controls.
// ----------------------------------------------------------------------------
package sqm_pkg;

    // operation codes
    localparam logic [2:0] FN_PUSH      = 3'd0;
    localparam logic [2:0] FN_PRINT_ALL = 3'd1;
    localparam logic [2:0] FN_PRINT_TOP = 3'd2;
    localparam logic [2:0] FN_POP       = 3'd3;
    localparam logic [2:0] FN_SWAP      = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BADPUSH    = 3'd1;
    localparam logic [2:0] ST_PRINTEMPTY = 3'd2;
    localparam logic [2:0] ST_POPEMPTY   = 3'd3;
    localparam logic [2:0] ST_SWAPSHORT  = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_HALTED     = 3'd6;

    // input request
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
        logic               push_value_ok;
    } t_in_req;

    // output response
    typedef struct packed {
        logic signed [31:0] out_value;
        logic               has_value;
        logic [2:0]         status;
        logic               last;
    } t_out_rsp;

    // memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PA_OUT,
        S_SW_RD1,
        S_SW_WR0,
        S_SW_WR1,
        S_RESULT
    } t_state;

    // single response that carries no entry
    function automatic t_out_rsp status_rsp(logic [2:0] status);
        t_out_rsp rsp;
        rsp.out_value = 32'sd0;
        rsp.has_value = 1'b0;
        rsp.status    = status;
        rsp.last      = 1'b1;
        return rsp;
    endfunction

endpackage

FILE: design/sqm_slot.sv
// ----------------------------------------------------------------------------
// sqm_slot
// Shared slot address unit: top position plus an offset, wrapped modulo DEPTH.
// ----------------------------------------------------------------------------
module sqm_slot #(
    parameter int DEPTH = 32
) (
    input  logic [$clog2(DEPTH)-1:0] i_top,
    input  logic [$clog2(DEPTH)-1:0] i_off,
    output logic [$clog2(DEPTH)-1:0] o_slot
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEP = (AW+1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    // add, then one conditional subtract since the sum stays below 2*DEPTH
    assign sum     = {1'b0, i_top} + {1'b0, i_off};
    assign wrapped = (sum >= DEP) ? (sum - DEP) : sum;
    assign o_slot  = wrapped[AW-1:0];

endmodule

FILE: design/sqm_mem.sv
// ----------------------------------------------------------------------------
// sqm_mem
// Entry storage: one shared address, synchronous write, registered read.
// ----------------------------------------------------------------------------
module sqm_mem
    import sqm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [31:0]              i_wdata,
    output logic [31:0]              o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sqm_ctrl.sv
// ----------------------------------------------------------------------------
// sqm_ctrl
// Operation sequencer: decodes one request, drives the slot unit and the
// entry memory step by step, and holds the response output register.
// ----------------------------------------------------------------------------
module sqm_ctrl
    import sqm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_mode,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_req                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_rsp                 o_out_data,
    output t_mem_ctl                 o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0] o_mem_addr,
    output logic [31:0]              o_mem_wdata,
    input  logic [31:0]              i_mem_rdata
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state          r_state, n_state;
    t_in_req         r_req, n_req;
    logic [AW-1:0]   r_top, n_top;
    logic [CW-1:0]   r_count, n_count;
    logic            r_halt, n_halt;
    logic [AW-1:0]   r_idx, n_idx;
    logic [31:0]     r_tmp, n_tmp;
    t_out_rsp        r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_out_rsp        r_out, n_out;

    logic [AW-1:0]   s_off;
    logic [AW-1:0]   s_slot;
    logic            out_free;
    logic            out_load;
    t_out_rsp        out_next;
    logic            pa_last;

    // shared slot address unit
    sqm_slot #(
        .DEPTH(DEPTH)
    ) u_slot (
        .i_top (r_top),
        .i_off (s_off),
        .o_slot(s_slot)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_mem_addr  = s_slot;
    assign pa_last     = (r_req.func == FN_PRINT_TOP) ||
                         ((CW'(r_idx) + CW'(1)) == r_count);

    // state and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_count     <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_count     <= n_count;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_tmp <= n_tmp;
        r_res <= n_res;
        r_out <= n_out;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_top       = r_top;
        n_count     = r_count;
        n_halt      = r_halt;
        n_idx       = r_idx;
        n_tmp       = r_tmp;
        n_res       = r_res;
        s_off       = '0;
        o_mem_ctl   = '0;
        o_mem_wdata = r_req.push_value;
        out_load    = 1'b0;
        out_next    = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_RESULT;
                n_res   = status_rsp(ST_OK);
                if (r_halt) begin
                    n_res = status_rsp(ST_HALTED);
                end else begin
                    unique case (r_req.func)
                        FN_PUSH: begin
                            if (!r_req.push_value_ok) begin
                                n_count = '0;
                                n_top   = '0;
                                n_halt  = 1'b1;
                                n_res   = status_rsp(ST_BADPUSH);
                            end else if (r_count == FULL_CNT) begin
                                n_res = status_rsp(ST_FULL);
                            end else begin
                                // top mode writes one slot above top, queue mode below the last
                                s_off           = i_mode ? r_count[AW-1:0] : AW'(DEPTH - 1);
                                o_mem_ctl.wr_en = 1'b1;
                                if (!i_mode) begin
                                    n_top = s_slot;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        FN_PRINT_ALL: begin
                            if (r_count != '0) begin
                                n_idx           = '0;
                                o_mem_ctl.rd_en = 1'b1;
                                n_state         = S_PA_OUT;
                            end
                        end
                        FN_PRINT_TOP: begin
                            if (r_count == '0) begin
                                n_count = '0;
                                n_top   = '0;
                                n_halt  = 1'b1;
                                n_res   = status_rsp(ST_PRINTEMPTY);
                            end else begin
                                n_idx           = '0;
                                o_mem_ctl.rd_en = 1'b1;
                                n_state         = S_PA_OUT;
                            end
                        end
                        FN_POP: begin
                            if (r_count == '0) begin
                                n_count = '0;
                                n_top   = '0;
                                n_halt  = 1'b1;
                                n_res   = status_rsp(ST_POPEMPTY);
                            end else begin
                                s_off   = AW'(1);
                                n_top   = s_slot;
                                n_count = r_count - CW'(1);
                            end
                        end
                        FN_SWAP: begin
                            if (r_count < CW'(2)) begin
                                n_count = '0;
                                n_top   = '0;
                                n_halt  = 1'b1;
                                n_res   = status_rsp(ST_SWAPSHORT);
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                n_state         = S_SW_RD1;
                            end
                        end
                        default: begin
                            n_res = status_rsp(ST_OK);
                        end
                    endcase
                end
            end

            // one entry per cycle while the output register is free, next read issued as the current one goes out
            S_PA_OUT: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_next.out_value = i_mem_rdata;
                    out_next.has_value = 1'b1;
                    out_next.status    = ST_OK;
                    out_next.last      = pa_last;
                    if (pa_last) begin
                        n_state = S_IDLE;
                    end else begin
                        s_off           = r_idx + AW'(1);
                        n_idx           = r_idx + AW'(1);
                        o_mem_ctl.rd_en = 1'b1;
                    end
                end
            end

            // swap: hold top word, fetch second, then write both back
            S_SW_RD1: begin
                n_tmp           = i_mem_rdata;
                s_off           = AW'(1);
                o_mem_ctl.rd_en = 1'b1;
                n_state         = S_SW_WR0;
            end

            S_SW_WR0: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = i_mem_rdata;
                n_state         = S_SW_WR1;
            end

            S_SW_WR1: begin
                s_off           = AW'(1);
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = r_tmp;
                n_res           = status_rsp(ST_OK);
                n_state         = S_RESULT;
            end

            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // response output register
        n_out_valid = out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        n_out       = out_load ? out_next : r_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // the count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds depth");

    // a halted block keeps an empty store
    a_halt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (r_count == '0 && r_top == '0))
        else $error("halted with entries");

    // a request seen while halted answers with the halted status
    a_halt_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE && r_halt) |=>
            (r_state == S_RESULT && r_res.status == ST_HALTED))
        else $error("halted request not answered as halted");

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !out_load)
        else $error("response register overwritten");
`endif

endmodule

FILE: design/stack_queue_machine.sv
// ----------------------------------------------------------------------------
// stack_queue_machine
// Bounded stack of signed 32-bit words with a queue mode for pushes.
// ----------------------------------------------------------------------------
// Each request carries one operation and is handled alone: the input is ready
// only while the sequencer is idle. Push, pop, an undefined code, any request
// while halted and print-top on an empty store pass decode and result; other
// print-tops and print-all on a non-empty store go from decode to the output
// state, one response per cycle when not stalled; swap runs decode, a read,
// two writes and result. These steps are set by the single-port entry memory
// with its registered read and one shared slot address unit that every access
// goes through. A response register sits on the output, so the next request
// is taken while a response still waits. Errors clear the store and halt until
// reset; the stack_mode register is written only while the block is idle.
module stack_queue_machine
    import sqm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_rsp o_out_data
);
    localparam int AW = $clog2(DEPTH);

    logic          r_mode;
    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    // stack_mode register, taken only while idle with no request offered
    assign o_cfg_ready = o_in_ready && !i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // sequencer
    sqm_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_mem_wdata(mem_wdata),
        .i_mem_rdata(mem_rdata)
    );

    // entry storage
    sqm_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

endmodule

FILE: tb/tb_stack_queue_machine.sv
// ----------------------------------------------------------------------------
// tb_stack_queue_machine
// Self-checking bench for the stack/queue machine. A queue of pending
// requests and mode writes feeds a valid/ready driver; a monitor on the rising
// edge keeps a shadow copy of the store, predicts every response and checks
// the responses field by field. A directed opening covers the field extremes
// and every operation, then random phases in both push modes run the store
// full and empty, and the run closes on one randomly chosen halting error.
// ----------------------------------------------------------------------------
module tb_stack_queue_machine;
    import sqm_pkg::*;

    localparam int DEPTH      = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 4;
    localparam int CALM_TAIL  = 60;
    localparam int MAX_PRINTS = 40;

    // operation codes the block treats as no-ops
    localparam logic [2:0] FN_RSVD5 = 3'd5;
    localparam logic [2:0] FN_RSVD6 = 3'd6;
    localparam logic [2:0] FN_RSVD7 = 3'd7;

    typedef enum logic {K_REQ, K_CFG} t_kind;

    typedef enum logic [1:0] {
        END_BADPUSH,
        END_PRINTEMPTY,
        END_POPEMPTY,
        END_SWAPSHORT
    } t_end_err;

    typedef struct {
        t_kind   kind;
        t_in_req req;
        logic    mode;
    } t_pending;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;
    logic     in_valid;
    logic     in_ready;
    t_in_req  in_data;
    logic     out_valid;
    logic     out_ready;
    t_out_rsp out_data;

    // handshakes seen at the last rising edge
    logic     in_fire;
    logic     cfg_fire;
    logic     rst_done;

    t_pending pending[$];
    t_out_rsp want_rsp[$];
    int       gen_count;
    logic     gen_done;

    int       gap_left;
    int       stall_left;
    int       settle_cnt;
    int       idle_cycles;

    // shadow of the block state
    logic signed [31:0] shadow_word [DEPTH];
    logic [4:0]         shadow_top;
    logic [5:0]         shadow_count;
    logic               shadow_halted;
    logic               stack_mode;

    int       n_err;
    int       n_req;
    int       n_rsp;
    int       n_cfg;
    int       n_full;
    int       longest_dump;
    t_end_err end_err;

    stack_queue_machine #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    wire calm = gen_done && (pending.size() < CALM_TAIL);

    task automatic report_mismatch(string what);
        n_err++;
        if (n_err <= MAX_PRINTS) begin
            $display("mismatch @%0t: %s", $time, what);
        end
    endtask

    // error path: store cleared, block stuck until reset
    task automatic halt_store();
        shadow_count  = '0;
        shadow_top    = '0;
        shadow_halted = 1'b1;
    endtask

    // expected responses of one accepted request, shadow state updated
    task automatic apply_stack_op(t_in_req r);
        t_out_rsp   rsp;
        logic [4:0] s0;
        logic [4:0] s1;
        logic signed [31:0] tmp;
        rsp      = '0;
        rsp.last = 1'b1;
        s0       = shadow_top;
        s1       = shadow_top + 5'd1;
        if (shadow_halted) begin
            rsp.status = ST_HALTED;
        end else begin
            case (r.func)
                FN_PUSH: begin
                    if (!r.push_value_ok) begin
                        rsp.status = ST_BADPUSH;
                        halt_store();
                    end else if (shadow_count >= DEPTH) begin
                        rsp.status = ST_FULL;
                        n_full++;
                    end else begin
                        if (stack_mode == 1'b0) begin
                            shadow_top = shadow_top - 5'd1;
                            shadow_word[shadow_top] = r.push_value;
                        end else begin
                            shadow_word[shadow_top + shadow_count[4:0]] = r.push_value;
                        end
                        shadow_count++;
                    end
                end
                FN_PRINT_ALL: begin
                    if (shadow_count != 0) begin
                        for (int i = 0; i < shadow_count; i++) begin
                            rsp.out_value = shadow_word[shadow_top + 5'(i)];
                            rsp.has_value = 1'b1;
                            rsp.last      = (i + 1 == shadow_count);
                            want_rsp.push_back(rsp);
                        end
                        if (shadow_count > longest_dump) longest_dump = shadow_count;
                        return;
                    end
                end
                FN_PRINT_TOP: begin
                    if (shadow_count == 0) begin
                        rsp.status = ST_PRINTEMPTY;
                        halt_store();
                    end else begin
                        rsp.out_value = shadow_word[s0];
                        rsp.has_value = 1'b1;
                    end
                end
                FN_POP: begin
                    if (shadow_count == 0) begin
                        rsp.status = ST_POPEMPTY;
                        halt_store();
                    end else begin
                        shadow_top = s1;
                        shadow_count--;
                    end
                end
                FN_SWAP: begin
                    if (shadow_count < 2) begin
                        rsp.status = ST_SWAPSHORT;
                        halt_store();
                    end else begin
                        tmp             = shadow_word[s0];
                        shadow_word[s0] = shadow_word[s1];
                        shadow_word[s1] = tmp;
                    end
                end
                default: ;
            endcase
        end
        want_rsp.push_back(rsp);
    endtask

    // request generation, shadow count kept for legal sequences
    task automatic queue_req(logic [2:0] fn, logic [31:0] value, logic ok);
        t_pending p;
        p.kind              = K_REQ;
        p.req.func          = fn;
        p.req.push_value    = value;
        p.req.push_value_ok = ok;
        p.mode              = 1'b0;
        pending.push_back(p);
        if (fn == FN_PUSH && ok && gen_count < DEPTH) begin
            gen_count++;
        end else if (fn == FN_POP && gen_count != 0) begin
            gen_count--;
        end
    endtask

    task automatic queue_mode(logic m);
        t_pending p;
        p.kind = K_CFG;
        p.req  = '0;
        p.mode = m;
        pending.push_back(p);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // legal operation for the current fill level, pushes weighted by pct
    task automatic queue_random_op(int push_pct);
        int          pick;
        logic [2:0]  fn;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 99) < push_pct) begin
            queue_req(FN_PUSH, pick_word(), 1'b1);
            return;
        end
        if (pick < 3) begin
            fn = FN_PRINT_ALL;
        end else if (pick < 8) begin
            fn = FN_PRINT_TOP;
        end else if (pick < 15) begin
            fn = FN_POP;
        end else if (pick < 18) begin
            fn = FN_SWAP;
        end else begin
            fn = 3'($urandom_range(FN_RSVD5, FN_RSVD7));
        end
        if ((fn == FN_PRINT_TOP || fn == FN_POP) && gen_count == 0) fn = FN_PRINT_ALL;
        if (fn == FN_SWAP && gen_count < 2) fn = FN_PRINT_ALL;
        // argument fields carry noise on everything but a push
        queue_req(fn, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic fill_to_full();
        while (gen_count < DEPTH) queue_req(FN_PUSH, pick_word(), 1'b1);
        queue_req(FN_PUSH, pick_word(), 1'b1);
        queue_req(FN_PUSH, pick_word(), 1'b1);
        queue_req(FN_PRINT_ALL, $urandom, 1'b0);
    endtask

    // request and mode write driver
    always @(negedge i_clk) begin : drive_p
        logic    nv;
        logic    ncv;
        logic    ncd;
        t_in_req nd;
        nv  = in_valid;
        nd  = in_data;
        ncv = cfg_valid;
        ncd = cfg_data;
        if (rst_done) begin
            if (in_valid && in_fire) nv = 1'b0;
            if (cfg_valid && cfg_fire) ncv = 1'b0;
            if (!nv && !ncv) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending.size() != 0) begin
                    if (pending[0].kind == K_REQ) begin
                        nv = 1'b1;
                        nd = pending[0].req;
                        void'(pending.pop_front());
                        if (!calm && $urandom_range(0, 6) == 0) begin
                            gap_left = $urandom_range(1, 14);
                        end
                    end else if (want_rsp.size() == 0 && settle_cnt >= SETTLE) begin
                        // mode writes only once the block has gone quiet
                        ncv = 1'b1;
                        ncd = pending[0].mode;
                        void'(pending.pop_front());
                    end
                end
            end
        end
        in_valid  <= nv;
        in_data   <= nd;
        cfg_valid <= ncv;
        cfg_data  <= ncd;
    end

    // response back-pressure
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_done;
            if (rst_done && !calm && $urandom_range(0, 8) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin : mon_p
        t_out_rsp want;
        logic     fi;
        logic     fo;
        logic     fc;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            fi = in_valid && in_ready;
            fo = out_valid && out_ready;
            fc = cfg_valid && cfg_ready;
            // responses first: they belong to earlier requests
            if (fo) begin
                n_rsp++;
                if (want_rsp.size() == 0) begin
                    report_mismatch($sformatf("unexpected response %p", out_data));
                end else begin
                    want = want_rsp.pop_front();
                    if (out_data.out_value !== want.out_value)
                        report_mismatch($sformatf("out_value %0d, want %0d",
                                                  out_data.out_value, want.out_value));
                    if (out_data.has_value !== want.has_value)
                        report_mismatch($sformatf("has_value %b, want %b",
                                                  out_data.has_value, want.has_value));
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  out_data.status, want.status));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  out_data.last, want.last));
                end
            end
            if (fc) begin
                stack_mode = cfg_data;
                n_cfg++;
            end
            if (fi) begin
                apply_stack_op(in_data);
                n_req++;
            end
            in_fire  <= fi;
            cfg_fire <= fc;

            if (fi || fo || want_rsp.size() != 0) begin
                settle_cnt = 0;
            end else if (settle_cnt < SETTLE) begin
                settle_cnt++;
            end

            if (fi || fo || fc) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                    $display("[stack_queue_machine] ERROR");
                    $finish;
                end
            end
        end
    end

    // reset, stimulus and end of run
    initial begin : stim_p
        int   push_pct [6];
        logic mode_seq [6];
        int   floor_cnt;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        out_ready     = 1'b0;
        in_fire       = 1'b0;
        cfg_fire      = 1'b0;
        rst_done      = 1'b0;
        gen_done      = 1'b0;
        gen_count     = 0;
        gap_left      = 0;
        stall_left    = 0;
        settle_cnt    = 0;
        idle_cycles   = 0;
        shadow_top    = '0;
        shadow_count  = '0;
        shadow_halted = 1'b0;
        stack_mode    = 1'b0;
        n_err         = 0;
        n_req         = 0;
        n_rsp         = 0;
        n_cfg         = 0;
        n_full        = 0;
        longest_dump  = 0;
        i_rst_n       = 1'b0;

        // directed opening, mode left at its reset value
        queue_req(FN_PRINT_ALL, $urandom, 1'b1);
        queue_req(FN_RSVD5, $urandom, 1'b0);
        queue_req(FN_RSVD6, $urandom, 1'b1);
        queue_req(FN_RSVD7, $urandom, 1'b0);
        queue_req(FN_PUSH, 32'h8000_0000, 1'b1);
        queue_req(FN_PUSH, 32'h7fff_ffff, 1'b1);
        queue_req(FN_PUSH, 32'h0000_0000, 1'b1);
        queue_req(FN_PUSH, 32'hffff_ffff, 1'b1);
        queue_req(FN_PRINT_TOP, $urandom, 1'b0);
        queue_req(FN_PRINT_ALL, $urandom, 1'b0);
        queue_req(FN_SWAP, $urandom, 1'b1);
        queue_req(FN_PRINT_TOP, $urandom, 1'b1);
        queue_req(FN_POP, $urandom, 1'b0);
        queue_req(FN_PRINT_ALL, $urandom, 1'b1);
        // queue mode: pushes land at the bottom
        queue_mode(1'b1);
        queue_req(FN_PUSH, 32'h5555_5555, 1'b1);
        queue_req(FN_PUSH, 32'haaaa_aaaa, 1'b1);
        queue_req(FN_PRINT_ALL, $urandom, 1'b0);
        queue_req(FN_SWAP, $urandom, 1'b0);
        queue_req(FN_PRINT_ALL, $urandom, 1'b1);
        queue_req(FN_POP, $urandom, 1'b1);
        queue_mode(1'b0);
        queue_req(FN_PUSH, 32'h0000_0001, 1'b1);
        queue_req(FN_PRINT_ALL, $urandom, 1'b0);

        // run the store full in stack mode, then back down
        fill_to_full();
        queue_req(FN_SWAP, $urandom, 1'b0);
        queue_req(FN_PRINT_TOP, $urandom, 1'b1);
        while (gen_count > DEPTH / 2) queue_req(FN_POP, $urandom, 1'b0);

        // random phases over both push modes
        push_pct = '{60, 35, 50, 70, 30, 55};
        mode_seq = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1))};
        for (int p = 0; p < 6; p++) begin
            queue_mode(mode_seq[p]);
            if (p == 2) fill_to_full();
            for (int k = 0; k < 55; k++) queue_random_op(push_pct[p]);
        end

        // close on one halting error, then requests against the halted block
        end_err = t_end_err'($urandom_range(0, 3));
        floor_cnt = (end_err == END_SWAPSHORT) ? $urandom_range(0, 1) : 0;
        if (end_err != END_BADPUSH) begin
            while (gen_count > floor_cnt) queue_req(FN_POP, $urandom, 1'b1);
        end
        case (end_err)
            END_BADPUSH:    queue_req(FN_PUSH, $urandom, 1'b0);
            END_PRINTEMPTY: queue_req(FN_PRINT_TOP, $urandom, 1'b1);
            END_POPEMPTY:   queue_req(FN_POP, $urandom, 1'b1);
            default:        queue_req(FN_SWAP, $urandom, 1'b1);
        endcase
        queue_req(FN_PUSH, pick_word(), 1'b1);
        queue_req(FN_PRINT_ALL, $urandom, 1'b1);
        for (int k = 0; k < 3; k++) queue_req(3'($urandom_range(0, 7)), $urandom, 1'b1);
        gen_done = 1'b1;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        while (pending.size() != 0 || in_valid || cfg_valid) @(posedge i_clk);
        while (want_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("ran %0d requests and %0d responses over %0d mode writes, %0d full refusals",
                 n_req, n_rsp, n_cfg, n_full);
        $display("longest print-all %0d entries, closed by %s", longest_dump, end_err.name());
        if (n_err == 0) begin
            $display("[stack_queue_machine] OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("[stack_queue_machine] ERROR");
        end
        $finish;
    end

endmodule
